@@ rtl/segment_address_translator_core_assert.svh @@
// Assertion macros shared by the checker of the address translator.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef SEGMENT_ADDRESS_TRANSLATOR_CORE_ASSERT_SVH
`define SEGMENT_ADDRESS_TRANSLATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment address translator check failed");

// Consequent must hold in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment address translator check failed");

`endif

@@ rtl/sat_pkg.sv @@
// Package for the segment address translator: widths, codes and shared types.
// No dependencies; every other file but the assertion macros header imports it.
package sat_pkg;

  localparam int WORD_W           = 32;
  localparam int CMD_W            = 2;
  localparam int ENTRY_IDX_W      = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int NUM_SECTIONS_DEF = 16;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE   = 2'd2;

  // Operations of the shared arithmetic unit.
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_PREP = 2'd0;
  localparam alu_op_t ALU_HDR  = 2'd1;
  localparam alu_op_t ALU_SCAN = 2'd2;

  // Section entry as held in the table: the start, the 33-bit exclusive end of
  // the covered range and the signed distance from virtual start to raw start.
  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W:0]   end_addr;
    logic [WORD_W+1:0] delta;
  } sec_entry_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] value;
    sec_entry_t        entry;
  } alu_res_t;

  typedef struct packed {
    logic we;
    logic clear;
  } tbl_ctrl_t;

endpackage

@@ rtl/sat_if.sv @@
// Request and result channel interfaces of the segment address translator.
// Depends on sat_pkg for the field widths.
interface sat_in_if
  import sat_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]       cmd;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [WORD_W-1:0]      virt_start;
  logic [WORD_W-1:0]      virt_size;
  logic [WORD_W-1:0]      raw_start;
  logic [WORD_W-1:0]      raw_size;
  logic [WORD_W-1:0]      lookup_address;

  modport source (output valid, cmd, entry_index, virt_start, virt_size, raw_start,
                  raw_size, lookup_address, input ready);
  modport sink (input valid, cmd, entry_index, virt_start, virt_size, raw_start,
                raw_size, lookup_address, output ready);
endinterface

interface sat_out_if
  import sat_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              found;
  logic [WORD_W-1:0] file_offset;

  modport source (output valid, found, file_offset, input ready);
  modport sink (input valid, found, file_offset, output ready);
endinterface

@@ rtl/sat_sec_table.sv @@
// Section table: entry memory with one write and one registered read port,
// plus a valid bit per slot in flip-flops. Depends on sat_pkg.
module sat_sec_table
  import sat_pkg::*;
#(
  parameter int NUM_SECTIONS = NUM_SECTIONS_DEF,
  parameter int IdxW         = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tbl_ctrl_t       ctrl,
  input  logic [IdxW-1:0] wr_addr,
  input  sec_entry_t      wr_data,
  input  logic [IdxW-1:0] rd_addr,
  output sec_entry_t      rd_data,
  output logic            rd_valid
);

  sec_entry_t              mem [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0] valid_r;
  logic [NUM_SECTIONS-1:0] valid_nxt;
  sec_entry_t              rd_data_r;
  logic                    rd_valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = '0;
    end else if (ctrl.we) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

@@ rtl/sat_alu.sv @@
// Shared arithmetic unit: prepares a section entry for storage, checks the
// header window and tests one section entry. Depends on sat_pkg.
module sat_alu
  import sat_pkg::*;
(
  input  alu_op_t           op,
  input  logic [WORD_W-1:0] addr,
  input  logic [WORD_W-1:0] image_base,
  input  logic [WORD_W-1:0] header_size,
  input  logic [WORD_W-1:0] file_size,
  input  sec_entry_t        entry,
  input  logic [WORD_W-1:0] virt_start,
  input  logic [WORD_W-1:0] virt_size,
  input  logic [WORD_W-1:0] raw_start,
  input  logic [WORD_W-1:0] raw_size,
  output alu_res_t          res
);

  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] rel;
  logic [WORD_W+1:0] pos;

  assign span = (virt_size > raw_size) ? virt_size : raw_size;
  assign rel  = addr - image_base;
  // The delta is kept in two's complement, so the sum is exact whenever the
  // address lies inside the section.
  assign pos  = {2'b00, addr} + entry.delta;

  always_comb begin
    res = '0;
    unique case (op)
      ALU_PREP: begin
        res.entry.start    = virt_start;
        res.entry.end_addr = {1'b0, virt_start} + {1'b0, span};
        res.entry.delta    = {2'b00, raw_start} - {2'b00, virt_start};
      end
      ALU_HDR: begin
        res.hit   = (addr >= image_base) && (rel < header_size) && (rel < file_size);
        res.value = rel;
      end
      ALU_SCAN: begin
        res.hit   = (addr >= entry.start) && ({1'b0, addr} < entry.end_addr) &&
                    (pos < {2'b00, file_size});
        res.value = pos[WORD_W-1:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

@@ rtl/segment_address_translator_core.sv @@
// Top level of the segment address translator: sequencer, configuration
// registers and result register. Depends on sat_pkg, sat_if, sat_sec_table and sat_alu.
//
// The block translates a virtual address into a file offset, first through the
// header window that starts at the image base, then through a table of
// NUM_SECTIONS section entries which is searched in index order. Every request
// gives exactly one result; only a translate request can report found, and a
// miss or any other command returns a zero offset. The block takes one request
// at a time. A translate request first tests the header window and, if that
// misses, searches the table one entry per cycle through its single read port
// and one shared arithmetic unit until an entry hits or the last entry has
// been tested. A section write passes through a write state, while a clear or
// an unused command goes straight to the hand-over state. A result that is not
// taken holds the next result back, and with it the block. The finished result
// sits in an output register, so the next request can be accepted while it
// waits to be taken. Section entries are converted on write into a start, an
// end and a raw-start delta so that each search step needs just one add and a
// few compares. Configuration registers may only be written while no request
// is in flight.
module segment_address_translator_core
  import sat_pkg::*;
#(
  parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sat_in_if.sink               in_ch,
  sat_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int IdxW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SECTIONS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic        res_found_r, res_found_nxt;
  logic [WORD_W-1:0] res_off_r, res_off_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r, out_found_nxt;
  logic [WORD_W-1:0] out_off_r, out_off_nxt;

  logic [WORD_W-1:0] image_base_r, header_size_r, file_size_r;

  // Request payload held for the duration of the request.
  logic [ENTRY_IDX_W-1:0] idx_r;
  logic [WORD_W-1:0] virt_start_r, virt_size_r, raw_start_r, raw_size_r, addr_r;

  logic        in_acc;
  logic        idx_in_range;
  tbl_ctrl_t   tbl_ctrl;
  logic [IdxW-1:0] rd_addr;
  sec_entry_t  rd_entry;
  logic        rd_valid;
  alu_op_t     alu_op;
  alu_res_t    alu_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Slots at or beyond the table depth are silently ignored on write.
  assign idx_in_range = ({{(WORD_W-ENTRY_IDX_W){1'b0}}, idx_r} < WORD_W'(NUM_SECTIONS));

  // The read address runs one entry ahead of the entry being tested.
  assign rd_addr = ((state_r == S_SCAN) && (cnt_r != LastIdx)) ? cnt_r + 1'b1 : '0;

  always_comb begin
    unique case (state_r)
      S_WRITE: alu_op = ALU_PREP;
      S_HDR:   alu_op = ALU_HDR;
      default: alu_op = ALU_SCAN;
    endcase
  end

  sat_sec_table #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .IdxW         (IdxW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (tbl_ctrl),
    .wr_addr  (IdxW'(idx_r)),
    .wr_data  (alu_res.entry),
    .rd_addr  (rd_addr),
    .rd_data  (rd_entry),
    .rd_valid (rd_valid)
  );

  sat_alu u_alu (
    .op          (alu_op),
    .addr        (addr_r),
    .image_base  (image_base_r),
    .header_size (header_size_r),
    .file_size   (file_size_r),
    .entry       (rd_entry),
    .virt_start  (virt_start_r),
    .virt_size   (virt_size_r),
    .raw_start   (raw_start_r),
    .raw_size    (raw_size_r),
    .res         (alu_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_off_nxt   = res_off_r;
    tbl_ctrl      = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_off_nxt   = out_off_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_found_nxt = 1'b0;
          res_off_nxt   = '0;
          unique case (in_ch.cmd)
            CMD_WRITE:     state_nxt = S_WRITE;
            CMD_TRANSLATE: state_nxt = S_HDR;
            CMD_CLEAR: begin
              tbl_ctrl.clear = 1'b1;
              state_nxt      = S_DONE;
            end
            default:       state_nxt = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        tbl_ctrl.we = idx_in_range;
        state_nxt   = S_DONE;
      end
      S_HDR: begin
        cnt_nxt = '0;
        if (alu_res.hit) begin
          res_found_nxt = 1'b1;
          res_off_nxt   = alu_res.value;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_valid && alu_res.hit) begin
          res_found_nxt = 1'b1;
          res_off_nxt   = alu_res.value;
          state_nxt     = S_DONE;
        end else if (cnt_r == LastIdx) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free or being emptied.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_off_nxt   = res_off_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    res_found_r <= res_found_nxt;
    res_off_r   <= res_off_nxt;
    out_found_r <= out_found_nxt;
    out_off_r   <= out_off_nxt;
    if (in_acc) begin
      idx_r        <= in_ch.entry_index;
      virt_start_r <= in_ch.virt_start;
      virt_size_r  <= in_ch.virt_size;
      raw_start_r  <= in_ch.raw_start;
      raw_size_r   <= in_ch.raw_size;
      addr_r       <= in_ch.lookup_address;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r  <= '0;
      header_size_r <= '0;
      file_size_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_BASE:  image_base_r  <= cfg_wdata;
        CFG_HEADER_SIZE: header_size_r <= cfg_wdata;
        CFG_FILE_SIZE:   file_size_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.file_offset = out_off_r;

endmodule

@@ rtl/sat_checker.sv @@
// Port-level checker for the segment address translator, bound to the top level.
// Depends on sat_pkg and the assertion macros header.
`include "segment_address_translator_core_assert.svh"

module sat_checker
  import sat_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [WORD_W-1:0] out_file_offset
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose results have not yet been taken.
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SAT_ASSERT_NOW(a_miss_zero_offset, out_valid && !out_found, out_file_offset == '0)
  `SAT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
  `SAT_ASSERT_NOW(a_no_spurious_result, out_valid, pend_r != 2'd0)
  `SAT_ASSERT_NOW(a_at_most_one_waiting, in_acc, pend_r < 2'd2)
  `SAT_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
                   out_valid && $stable(out_found) && $stable(out_file_offset))

endmodule

bind segment_address_translator_core sat_checker u_sat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_file_offset (out_ch.file_offset)
);

@@ tb/sv/tb_segment_address_translator_core.sv @@
// Self-checking testbench for segment_address_translator_core: a directed
// run, then random requests under several register settings.
// Depends on sat_pkg, the channel interfaces in sat_if and the core itself.
module tb_segment_address_translator_core
  import sat_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SECTION_COUNT  = NUM_SECTIONS_DEF;
  localparam int unsigned CYCLE_LIMIT    = 500_000;
  localparam int          ITEMS_PER_PASS = 136;
  localparam int          SETTLE_CYCLES  = SECTION_COUNT + 8;

  // The package names three commands; the fourth code must leave the table
  // untouched and still return an empty result.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [WORD_W-1:0]      virt_start;
    logic [WORD_W-1:0]      virt_size;
    logic [WORD_W-1:0]      raw_start;
    logic [WORD_W-1:0]      raw_size;
    logic [WORD_W-1:0]      lookup_address;
  } section_req_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] file_offset;
  } offset_result_t;

  // The scoreboard keeps its own copy of the registers and the section table.
  // Each accepted request is run through it at once, and the answer waits in
  // pending_offsets until the matching result comes out of the core.
  class translation_scoreboard;
    logic [WORD_W-1:0] image_base;
    logic [WORD_W-1:0] header_size;
    logic [WORD_W-1:0] file_size;
    bit                sec_valid  [SECTION_COUNT];
    logic [WORD_W-1:0] sec_start  [SECTION_COUNT];
    logic [WORD_W-1:0] sec_vsize  [SECTION_COUNT];
    logic [WORD_W-1:0] sec_rstart [SECTION_COUNT];
    logic [WORD_W-1:0] sec_rsize  [SECTION_COUNT];
    offset_result_t    pending_offsets[$];
    int unsigned       failures, requests, translations, hits, writes, clears;

    function new();
      image_base  = '0;
      header_size = '0;
      file_size   = '0;
      foreach (sec_valid[k]) begin
        sec_valid[k]  = 1'b0;
        sec_start[k]  = '0;
        sec_vsize[k]  = '0;
        sec_rstart[k] = '0;
        sec_rsize[k]  = '0;
      end
      failures = 0;
      requests = 0;
      translations = 0;
      hits = 0;
      writes = 0;
      clears = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        CFG_IMAGE_BASE:  image_base  = value;
        CFG_HEADER_SIZE: header_size = value;
        CFG_FILE_SIZE:   file_size   = value;
        default: ;
      endcase
    endfunction

    // Header window first, then the valid sections in index order. The range
    // end and the raw position are both worked out 33 bits wide.
    function bit map_address(logic [WORD_W-1:0] addr, output logic [WORD_W-1:0] offs);
      logic [WORD_W-1:0] rel;
      logic [WORD_W-1:0] span;
      logic [WORD_W:0]   lo, hi, pos;
      offs = '0;
      if (addr >= image_base) begin
        rel = addr - image_base;
        if (rel < header_size && rel < file_size) begin
          offs = rel;
          return 1'b1;
        end
      end
      for (int k = 0; k < SECTION_COUNT; k++) begin
        if (sec_valid[k]) begin
          span = (sec_vsize[k] > sec_rsize[k]) ? sec_vsize[k] : sec_rsize[k];
          lo   = {1'b0, sec_start[k]};
          hi   = lo + {1'b0, span};
          if ({1'b0, addr} >= lo && {1'b0, addr} < hi) begin
            pos = {1'b0, sec_rstart[k]} + ({1'b0, addr} - lo);
            if (pos < {1'b0, file_size}) begin
              offs = pos[WORD_W-1:0];
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(section_req_t req);
      offset_result_t res;
      logic [WORD_W-1:0] offs;
      res = '0;
      requests++;
      case (req.cmd)
        CMD_WRITE: begin
          writes++;
          sec_valid[req.entry_index]  = 1'b1;
          sec_start[req.entry_index]  = req.virt_start;
          sec_vsize[req.entry_index]  = req.virt_size;
          sec_rstart[req.entry_index] = req.raw_start;
          sec_rsize[req.entry_index]  = req.raw_size;
        end
        CMD_TRANSLATE: begin
          translations++;
          if (map_address(req.lookup_address, offs)) begin
            hits++;
            res.found       = 1'b1;
            res.file_offset = offs;
          end
        end
        CMD_CLEAR: begin
          clears++;
          foreach (sec_valid[k]) sec_valid[k] = 1'b0;
        end
        default: ;
      endcase
      pending_offsets.insert(pending_offsets.size(), res);
    endfunction

    function void check_result(logic found, logic [WORD_W-1:0] file_offset);
      offset_result_t want;
      if (pending_offsets.size() == 0) begin
        failures++;
        $display("%0t: unexpected result found=%0b offset=%h with no request outstanding",
                 $time, found, file_offset);
        return;
      end
      want = pending_offsets.pop_front();
      if (found !== want.found) begin
        failures++;
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, found);
      end
      if (file_offset !== want.file_offset) begin
        failures++;
        $display("%0t: file_offset mismatch, expected %h, actual %h",
                 $time, want.file_offset, file_offset);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  sat_in_if  in_ch();
  sat_out_if out_ch();

  translation_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;
  bit          sender_quiet = 1'b0;

  segment_address_translator_core #(
    .NUM_SECTIONS(SECTION_COUNT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // A 4 ns clock: 2 ns high, 2 ns low.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog. The limit sits far above the slowest legal run, which is roughly
  // a thousand requests each paying the longest sender gap, the full section
  // scan and the longest result stall, plus the pauses between settings.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding",
               $time, sb.pending_offsets.size());
      $display("[segment_address_translator_core] ERROR");
      $finish;
    end
  end

  // A quiet side never holds back, which gives stretches of back-to-back traffic.
  function automatic int unsigned draw_wait(input bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic section_req_t make_req(
    input logic [CMD_W-1:0]       cmd,
    input logic [ENTRY_IDX_W-1:0] idx,
    input logic [WORD_W-1:0]      vs, vsz, rs, rsz, addr
  );
    section_req_t r;
    r.cmd            = cmd;
    r.entry_index    = idx;
    r.virt_start     = vs;
    r.virt_size      = vsz;
    r.raw_start      = rs;
    r.raw_size       = rsz;
    r.lookup_address = addr;
    return r;
  endfunction

  // Random requests are shaped so that most translations land on or next to
  // something real: the header window, the edges of a valid section, or the
  // bottom of the image. Sections are laid out near the image base so that
  // they overlap, with occasional empty ones, ones whose raw data runs past
  // the end of the file and ones whose range crosses the top of the 32-bit
  // space. Every field starts fully random, so unused fields toggle as well.
  function automatic section_req_t random_request();
    section_req_t      r;
    int unsigned       pick, kind, k;
    logic [WORD_W-1:0] span;
    r.cmd            = CMD_W'($urandom);
    r.entry_index    = ENTRY_IDX_W'($urandom);
    r.virt_start     = $urandom;
    r.virt_size      = $urandom;
    r.raw_start      = $urandom;
    r.raw_size       = $urandom;
    r.lookup_address = $urandom;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    if (pick < 34) begin
      r.cmd = CMD_WRITE;
      if (kind <= 7) begin
        r.virt_start = sb.image_base + $urandom_range(0, 32'h0004_0000);
        r.virt_size  = $urandom_range(0, 32'h4000);
        r.raw_size   = $urandom_range(0, 32'h4000);
        r.raw_start  = $urandom_range(0, sb.file_size);
      end
      if (kind == 6) begin
        r.virt_size = '0;
        r.raw_size  = '0;
      end else if (kind == 7) begin
        r.raw_start = sb.file_size - $urandom_range(0, 32'h100);
      end else if (kind == 8) begin
        r.virt_start = 32'hFFFF_FFFF - $urandom_range(0, 32'h1000);
        r.virt_size  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h2000);
      end
    end else if (pick < 94) begin
      r.cmd = CMD_TRANSLATE;
      if (kind <= 4) begin
        k = $urandom_range(0, SECTION_COUNT - 1);
        if (sb.sec_valid[k]) begin
          span = (sb.sec_vsize[k] > sb.sec_rsize[k]) ? sb.sec_vsize[k] : sb.sec_rsize[k];
          case ($urandom_range(0, 4))
            0: r.lookup_address = sb.sec_start[k];
            1: r.lookup_address = sb.sec_start[k] - 1;
            2: r.lookup_address = sb.sec_start[k] + span - 1;
            3: r.lookup_address = sb.sec_start[k] + span;
            default: r.lookup_address = sb.sec_start[k] + $urandom_range(0, span);
          endcase
        end
      end else if (kind <= 6) begin
        r.lookup_address = sb.image_base + $urandom_range(0, sb.header_size);
      end else if (kind == 7) begin
        r.lookup_address = sb.image_base - $urandom_range(1, 16);
      end else if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: r.lookup_address = '0;
          1: r.lookup_address = '1;
          default: r.lookup_address = sb.image_base;
        endcase
      end
    end else if (pick < 97) begin
      r.cmd = CMD_CLEAR;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  // Presents one request after a random gap and holds it until the core takes
  // it. Valid stays high on return, so a following request with no gap goes
  // straight out on the next falling edge.
  task automatic send_request(input section_req_t req);
    int unsigned gap;
    gap = draw_wait(sender_quiet);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd            = req.cmd;
    in_ch.entry_index    = req.entry_index;
    in_ch.virt_start     = req.virt_start;
    in_ch.virt_size      = req.virt_size;
    in_ch.raw_start      = req.raw_start;
    in_ch.raw_size       = req.raw_size;
    in_ch.lookup_address = req.lookup_address;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(req);
  endtask

  // Withdraws the request line and waits until every result is back, then
  // gives the core time to settle completely before anything else happens.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // All three registers are rewritten for every setting; only call this with
  // the core idle.
  task automatic program_config(input logic [WORD_W-1:0] base, hdr, fsz);
    write_register(CFG_IMAGE_BASE, base);
    write_register(CFG_HEADER_SIZE, hdr);
    write_register(CFG_FILE_SIZE, fsz);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Result side: waits a random number of cycles before each result, and now
  // and then switches to taking results as soon as they appear.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      stall = draw_wait(quiet);
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.found, out_ch.file_offset);
      taken++;
      if (taken % 80 == 0) quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // Main sequence.
  initial begin
    logic [WORD_W-1:0] base, hdr, fsz;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_IMAGE_BASE;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_WRITE;
    in_ch.entry_index    = '0;
    in_ch.virt_start     = '0;
    in_ch.virt_size      = '0;
    in_ch.raw_start      = '0;
    in_ch.raw_size       = '0;
    in_ch.lookup_address = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with a small image at 0x0040_0000: a 4 KiB header
    // window and a 128 KiB file.
    program_config(32'h0040_0000, 32'h0000_1000, 32'h0002_0000);
    // Header window: its first byte, its last byte, the byte just past it,
    // and an address just below the image base, with the table still empty.
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_0000));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_0FFF));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_1000));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h003F_FFFF));
    // An ordinary section, probed at its start, its last byte and just past it.
    send_request(make_req(CMD_WRITE, 4'd0, 32'h0040_1000, 32'h2000, 32'h400, 32'h1800, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_1000));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_2FFF));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_3000));
    // A section of zero span covers nothing, even its own start.
    send_request(make_req(CMD_WRITE, 4'd15, 32'h0050_0000, '0, 32'h10, '0, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0050_0000));
    // Two sections over the same range: the first runs off the end of the
    // file part-way through, so the search must fall through to the second.
    send_request(make_req(CMD_WRITE, 4'd2, 32'h0060_0000, 32'h10, 32'h0001_FFF8, 32'h10, '0));
    send_request(make_req(CMD_WRITE, 4'd3, 32'h0060_0000, 32'h20, 32'h10, '0, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0060_0007));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0060_0008));
    // A section whose end lies beyond the top of the 32-bit space.
    send_request(make_req(CMD_WRITE, 4'd4, 32'hFFFF_FF00, 32'hFFFF_FFFF, '0, '0, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    // Raw start at the top, so the raw position needs the 33rd bit.
    send_request(make_req(CMD_WRITE, 4'd5, 32'h0070_0000, 32'h4, 32'hFFFF_FFFF, 32'h8, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0070_0001));
    // The unused command code, then a clear, after which the table is empty.
    send_request(make_req(CMD_UNUSED, 4'hF, '1, '1, '1, '1, '1));
    send_request(make_req(CMD_CLEAR, 4'd0, '0, '0, '0, '0, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, 32'h0040_1000));
    // Entries with every field at its extremes.
    send_request(make_req(CMD_WRITE, 4'hF, '1, '1, '1, '1, '1));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '0, '0, '0, '0, '0));
    send_request(make_req(CMD_WRITE, 4'd6, '0, '0, '0, '0, '0));
    send_request(make_req(CMD_TRANSLATE, 4'd0, '1, '1, '1, '1, '0));
    wait_idle();

    // Random part. Each pass runs under its own register setting, all-zero
    // and all-ones among them; two passes keep the sender gapless.
    for (int pass = 0; pass < 7; pass++) begin
      case (pass)
        0: begin base = '0; hdr = '0; fsz = '0; end
        1: begin base = '1; hdr = '1; fsz = '1; end
        2: begin base = 32'h1000_0000; hdr = 32'h400; fsz = 32'h0010_0000; end
        3: begin base = $urandom; hdr = $urandom_range(0, 32'h0001_0000); fsz = $urandom; end
        4: begin base = '0; hdr = '1; fsz = 32'h8000; end
        5: begin base = $urandom; hdr = $urandom; fsz = $urandom_range(0, 32'h0100_0000); end
        default: begin base = 32'hFFFF_F000; hdr = 32'h2000; fsz = '1; end
      endcase
      program_config(base, hdr, fsz);
      sender_quiet = (pass == 2 || pass == 5);
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        // Once, half-way through a pass, hold off until the core has drained.
        if (pass == 3 && n == ITEMS_PER_PASS / 2) wait_idle();
        send_request(random_request());
      end
      wait_idle();
    end

    if (sb.pending_offsets.size() != 0) begin
      sb.failures++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending_offsets.size());
    end
    $display("Covered %0d requests under %0d register settings: %0d section writes,",
             sb.requests, settings_used, sb.writes);
    $display("%0d clears and %0d translations, of which %0d were found.",
             sb.clears, sb.translations, sb.hits);
    if (sb.failures == 0) begin
      $display("[segment_address_translator_core] OK");
    end else begin
      $display("[segment_address_translator_core] ERROR");
    end
    $finish;
  end

endmodule
